### sv/kps_pkg.sv
// Shared constants, codes and types of the keyframe pose sampler.
package kps_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int MAX_KEYS = 64;
  localparam int NUM_TRACKS = 3;
  localparam int NUM_TRK = MAX_CHANNELS * NUM_TRACKS;
  localparam int NUM_SLOTS = NUM_TRK * MAX_KEYS;
  localparam int TRK_W = $clog2(NUM_TRK);
  localparam int KEY_AW = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam int DIV_NUM_W = 49;
  localparam int DIV_Q_W = 17;

  localparam logic [16:0] Q_ONE = 17'h10000;
  localparam logic [31:0] Q_ONE_W = 32'h0001_0000;

  localparam logic [2:0] CMD_LOAD_T = 3'd0;
  localparam logic [2:0] CMD_LOAD_R = 3'd1;
  localparam logic [2:0] CMD_LOAD_S = 3'd2;
  localparam logic [2:0] CMD_SAMPLE = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [1:0] ST_SAMPLED = 2'd0;
  localparam logic [1:0] ST_STORED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0] cmd;
    logic [6:0] channel;
    logic [31:0] sample_time;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic signed [31:0] value_w;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [31:0] rot_w;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } result_t;

  typedef struct packed {
    logic [31:0] key_time;
    logic [31:0] comp_w;
    logic [31:0] comp_z;
    logic [31:0] comp_y;
    logic [31:0] comp_x;
  } key_word_t;

  typedef logic signed [32:0] qcomp_t;

  typedef struct packed {
    logic start;
    logic [DIV_NUM_W-1:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

endpackage

### sv/kps_ram.sv
// Generic single-port synchronous RAM with registered read.
module kps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/kps_div.sv
// Restoring divider producing a 17-bit quotient, one bit per cycle.
module kps_div import kps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [31:0] rem;
  logic [DIV_Q_W-1:0] numsh;
  logic [31:0] den;
  logic [DIV_Q_W-1:0] quot;
  logic [4:0] cnt;
  logic run;
  logic done_r;
  logic [32:0] trial;

  assign trial = {rem, numsh[DIV_Q_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem <= req.num[DIV_NUM_W-1:DIV_Q_W];
        numsh <= req.num[DIV_Q_W-1:0];
        den <= req.den;
        cnt <= 5'(DIV_Q_W - 1);
        run <= 1'b1;
      end else if (run) begin
        if (trial >= {1'b0, den}) begin
          rem <= 32'(trial - {1'b0, den});
          quot <= {quot[DIV_Q_W-2:0], 1'b1};
        end else begin
          rem <= trial[31:0];
          quot <= {quot[DIV_Q_W-2:0], 1'b0};
        end
        numsh <= {numsh[DIV_Q_W-2:0], 1'b0};
        if (cnt == 5'd0) begin
          run <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot;

endmodule

### sv/kps_sqrt.sv
// Digit-by-digit integer square root of a 64-bit value, one root bit per cycle.
module kps_sqrt import kps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done,
  output logic [31:0] root
);

  logic [33:0] rem;
  logic [63:0] vsh;
  logic [4:0] cnt;
  logic run;
  logic [35:0] r2;
  logic [35:0] trial;

  assign r2 = {rem, vsh[63:62]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        root <= '0;
        vsh <= val;
        cnt <= 5'd31;
        run <= 1'b1;
      end else if (run) begin
        if (r2 >= trial) begin
          rem <= 34'(r2 - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          rem <= r2[33:0];
          root <= {root[30:0], 1'b0};
        end
        vsh <= {vsh[61:0], 2'b00};
        if (cnt == 5'd0) begin
          run <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

endmodule

### sv/kps_norm.sv
// Quaternion normalizer: sum of squares, square root, then one division per component; a zero sum gives the identity.
module kps_norm import kps_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  qcomp_t qin [4],
  output logic   done,
  output qcomp_t qout [4]
);

  typedef enum logic [5:0] {
    N_IDLE = 6'b000001,
    N_SQ   = 6'b000010,
    N_CHK  = 6'b000100,
    N_ROOT = 6'b001000,
    N_DIVS = 6'b010000,
    N_DIVW = 6'b100000
  } nst_t;

  nst_t st;
  logic [31:0] mag [4];
  logic [3:0] neg;
  logic [63:0] prod;
  logic [63:0] acc;
  logic sat;
  logic [2:0] idx;
  logic [1:0] ci;
  logic [31:0] nroot;
  logic [64:0] sum65;
  logic sq_start;
  logic sq_done;
  logic [31:0] sq_root;
  div_req_t dreq;
  div_rsp_t drsp;

  assign sum65 = {1'b0, acc} + {1'b0, prod};
  assign sq_start = (st == N_CHK) && (acc != 64'd0);
  assign dreq.start = (st == N_DIVS);
  assign dreq.num = {1'b0, mag[ci], 16'b0} + {18'b0, nroot[31:1]};
  assign dreq.den = nroot;

  kps_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .val   (acc),
    .done  (sq_done),
    .root  (sq_root)
  );

  kps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= N_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 4; i++) begin
              neg[i] <= qin[i][32];
              mag[i] <= qin[i][32] ? 32'(-qin[i]) : qin[i][31:0];
            end
            acc <= '0;
            sat <= 1'b0;
            idx <= '0;
            st <= N_SQ;
          end
        end
        N_SQ: begin
          if (idx != 3'd4) begin
            prod <= mag[idx[1:0]] * mag[idx[1:0]];
          end
          if (idx != 3'd0) begin
            if (sat || sum65[64]) begin
              acc <= '1;
              sat <= 1'b1;
            end else begin
              acc <= sum65[63:0];
            end
          end
          idx <= idx + 3'd1;
          if (idx == 3'd4) begin
            st <= N_CHK;
          end
        end
        N_CHK: begin
          if (acc == 64'd0) begin
            qout[0] <= '0;
            qout[1] <= '0;
            qout[2] <= '0;
            qout[3] <= 33'sd65536;
            done <= 1'b1;
            st <= N_IDLE;
          end else begin
            st <= N_ROOT;
          end
        end
        N_ROOT: begin
          if (sq_done) begin
            nroot <= sq_root;
            ci <= '0;
            st <= N_DIVS;
          end
        end
        N_DIVS: begin
          st <= N_DIVW;
        end
        N_DIVW: begin
          if (drsp.done) begin
            qout[ci] <= neg[ci] ? 33'(33'd0 - {16'b0, drsp.quot}) : {16'b0, drsp.quot};
            if (ci == 2'd3) begin
              done <= 1'b1;
              st <= N_IDLE;
            end else begin
              ci <= ci + 2'd1;
              st <= N_DIVS;
            end
          end
        end
        default: st <= N_IDLE;
      endcase
    end
  end

endmodule

### sv/keyframe_pose_sampler_unit.sv
// Top level of the keyframe pose sampler: key storage, track search and interpolation.
//
//   channel   signals                     direction  transaction
//   item      start, busy, item           in         start high while busy low
//   result    done, result                out        done high for one cycle
//   config    cfg_we, cfg_data            in         cfg_we high
//
// A clear or a rejected command goes from the decode state straight to the result state and a
// load passes through a read state and a write state first; the unit returns to idle after each
// result. A sample walks its three tracks in turn: an empty track only reads its count, else
// the first and last keys are checked, key pairs are scanned and the factor is divided; a
// vector track then interpolates its three components and a rotation track runs 18
// normalizations (2 when the factor is one). Synchronous reset clears the track counts at once
// through per-track valid bits, so no clearing pass runs. Results cannot be stalled; busy stays
// high until the result cycle has passed.
module keyframe_pose_sampler_unit import kps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result,
  input  logic    cfg_we,
  input  logic [6:0] cfg_data
);

  typedef enum logic [24:0] {
    S_IDLE    = 25'b1 << 0,
    S_DECODE  = 25'b1 << 1,
    S_LD_RD   = 25'b1 << 2,
    S_LD_WR   = 25'b1 << 3,
    S_T_CNT   = 25'b1 << 4,
    S_T_CHK   = 25'b1 << 5,
    S_T_FIRST = 25'b1 << 6,
    S_T_LAST  = 25'b1 << 7,
    S_T_SCAN  = 25'b1 << 8,
    S_T_DIV   = 25'b1 << 9,
    S_INTERP  = 25'b1 << 10,
    S_L_M0    = 25'b1 << 11,
    S_L_M1    = 25'b1 << 12,
    S_L_M2    = 25'b1 << 13,
    S_R_NA    = 25'b1 << 14,
    S_R_WA    = 25'b1 << 15,
    S_R_NB    = 25'b1 << 16,
    S_R_WB    = 25'b1 << 17,
    S_R_DM    = 25'b1 << 18,
    S_R_DE    = 25'b1 << 19,
    S_R_BS    = 25'b1 << 20,
    S_R_BW    = 25'b1 << 21,
    S_R_OUT   = 25'b1 << 22,
    S_T_NEXT  = 25'b1 << 23,
    S_FIN     = 25'b1 << 24
  } state_t;

  function automatic logic [31:0] kw_comp(input key_word_t kw, input logic [1:0] i);
    logic [31:0] v;
    unique case (i)
      2'd0: v = kw.comp_x;
      2'd1: v = kw.comp_y;
      2'd2: v = kw.comp_z;
      default: v = kw.comp_w;
    endcase
    return v;
  endfunction

  state_t st;
  item_t it;
  result_t res;
  logic [6:0] chan_count;
  logic [1:0] trk_sel;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] scan_idx;
  key_word_t a_word;
  key_word_t b_word;
  logic [16:0] f_r;
  logic [1:0] comp;
  logic [65:0] acc_l;
  logic signed [35:0] dacc;
  logic [3:0] bit_i;
  qcomp_t p [4];
  qcomp_t q [4];
  qcomp_t qsel [4];
  logic [NUM_TRK-1:0] cnt_valid;
  logic valid_q;

  logic [TRK_W-1:0] cur_trk;
  logic [CNT_W-1:0] rd_idx;
  logic [KEY_AW-1:0] key_addr;
  logic key_we;
  logic [$bits(key_word_t)-1:0] key_rdata;
  key_word_t kw;
  key_word_t key_wdata;
  logic cnt_we;
  logic [CNT_W-1:0] cnt_rdata;
  logic [CNT_W-1:0] cnt_rd;
  logic [7:0] limit;
  logic ok;
  logic hit;
  logic [31:0] span;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_q;
  logic [65:0] lsum;
  logic [31:0] lerp_val;
  logic signed [35:0] d_tot;
  logic norm_start;
  qcomp_t norm_in [4];
  logic norm_done;
  qcomp_t norm_out [4];
  div_req_t fdiv_req;
  div_rsp_t fdiv_rsp;

  assign busy = (st != S_IDLE);
  assign done = (st == S_FIN);
  assign result = res;

  assign cur_trk = TRK_W'(32'(it.channel) * NUM_TRACKS + 32'(trk_sel));
  assign key_addr = KEY_AW'(32'(cur_trk) * MAX_KEYS + 32'(rd_idx));
  assign kw = key_word_t'(key_rdata);
  assign cnt_rd = valid_q ? cnt_rdata : '0;
  assign limit = (chan_count > 7'(MAX_CHANNELS)) ? 8'(MAX_CHANNELS) : {1'b0, chan_count};
  assign ok = {1'b0, it.channel} < limit;
  assign hit = (it.sample_time >= a_word.key_time) && (it.sample_time <= kw.key_time);
  assign span = kw.key_time - a_word.key_time;

  assign key_we = (st == S_LD_WR) && (cnt_rd < CNT_W'(MAX_KEYS));
  assign cnt_we = key_we;
  assign key_wdata = '{key_time: it.sample_time, comp_w: it.value_w, comp_z: it.value_z,
                       comp_y: it.value_y, comp_x: it.value_x};

  always_comb begin
    unique case (st)
      S_T_FIRST: rd_idx = n_r - CNT_W'(1);
      S_T_LAST:  rd_idx = CNT_W'(1);
      S_T_SCAN:  rd_idx = scan_idx + CNT_W'(1);
      S_LD_WR:   rd_idx = cnt_rd;
      default:   rd_idx = '0;
    endcase
  end

  kps_ram #(.WIDTH($bits(key_word_t)), .DEPTH(NUM_SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .addr  (key_addr),
    .wdata (key_wdata),
    .rdata (key_rdata)
  );

  kps_ram #(.WIDTH(CNT_W), .DEPTH(NUM_TRK)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .addr  (cur_trk),
    .wdata (cnt_rd + CNT_W'(1)),
    .rdata (cnt_rdata)
  );

  assign fdiv_req.start = (st == S_T_SCAN) && hit && (span != 32'd0);
  assign fdiv_req.num = {1'b0, it.sample_time - a_word.key_time, 16'b0};
  assign fdiv_req.den = span;

  kps_div u_fdiv (
    .clk (clk),
    .rst (rst),
    .req (fdiv_req),
    .rsp (fdiv_rsp)
  );

  assign norm_start = (st == S_R_NA) || (st == S_R_NB) || (st == S_R_BS);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (st == S_R_NA) begin
        norm_in[i] = qcomp_t'($signed(kw_comp(a_word, 2'(i))));
      end else if (st == S_R_NB) begin
        norm_in[i] = qcomp_t'($signed(kw_comp(b_word, 2'(i))));
      end else begin
        norm_in[i] = p[i] + q[i];
      end
    end
  end

  kps_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .qin   (norm_in),
    .done  (norm_done),
    .qout  (norm_out)
  );

  always_comb begin
    unique case (st)
      S_L_M0: begin
        mul_a = {1'b0, kw_comp(a_word, comp) ^ 32'h8000_0000};
        mul_b = {16'b0, Q_ONE - f_r};
      end
      S_L_M1: begin
        mul_a = {1'b0, kw_comp(b_word, comp) ^ 32'h8000_0000};
        mul_b = {16'b0, f_r};
      end
      S_R_DM: begin
        mul_a = p[comp];
        mul_b = q[comp];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
  end

  assign lsum = acc_l + 66'(mul_q) + 66'd32768;
  assign lerp_val = lsum[47:16] ^ 32'h8000_0000;
  assign d_tot = dacc + $signed(mul_q[35:0]);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qsel[i] = d_tot[35] ? -q[i] : q[i];
    end
  end

  always_ff @(posedge clk) begin
    valid_q <= cnt_valid[cur_trk];
    if (rst) begin
      st <= S_IDLE;
      chan_count <= '0;
      cnt_valid <= '0;
    end else begin
      if (cfg_we) begin
        chan_count <= cfg_data;
      end
      unique case (st)
        S_IDLE: begin
          if (start) begin
            it <= item;
            res <= '0;
            st <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (it.cmd > CMD_CLEAR || !ok) begin
            res.status <= ST_RANGE;
            if (it.cmd == CMD_SAMPLE) begin
              res.rot_w <= Q_ONE_W;
              res.scale_x <= Q_ONE_W;
              res.scale_y <= Q_ONE_W;
              res.scale_z <= Q_ONE_W;
            end
            st <= S_FIN;
          end else if (it.cmd == CMD_SAMPLE) begin
            res.status <= ST_SAMPLED;
            trk_sel <= 2'd0;
            st <= S_T_CNT;
          end else if (it.cmd == CMD_CLEAR) begin
            cnt_valid <= cnt_valid & ~(NUM_TRK'(3'b111) << (32'(it.channel) * NUM_TRACKS));
            res.status <= ST_STORED;
            st <= S_FIN;
          end else begin
            trk_sel <= it.cmd[1:0];
            st <= S_LD_RD;
          end
        end
        S_LD_RD: begin
          st <= S_LD_WR;
        end
        S_LD_WR: begin
          if (key_we) begin
            cnt_valid[cur_trk] <= 1'b1;
            res.status <= ST_STORED;
          end else begin
            res.status <= ST_FULL;
          end
          st <= S_FIN;
        end
        S_T_CNT: begin
          st <= S_T_CHK;
        end
        S_T_CHK: begin
          n_r <= cnt_rd;
          if (cnt_rd == '0) begin
            if (trk_sel == 2'd1) begin
              res.rot_w <= Q_ONE_W;
            end else if (trk_sel == 2'd2) begin
              res.scale_x <= Q_ONE_W;
              res.scale_y <= Q_ONE_W;
              res.scale_z <= Q_ONE_W;
            end
            st <= S_T_NEXT;
          end else begin
            st <= S_T_FIRST;
          end
        end
        S_T_FIRST: begin
          a_word <= kw;
          b_word <= kw;
          f_r <= '0;
          if (n_r == CNT_W'(1) || it.sample_time <= kw.key_time) begin
            st <= S_INTERP;
          end else begin
            st <= S_T_LAST;
          end
        end
        S_T_LAST: begin
          if (it.sample_time >= kw.key_time) begin
            a_word <= kw;
            b_word <= kw;
            st <= S_INTERP;
          end else begin
            scan_idx <= CNT_W'(1);
            st <= S_T_SCAN;
          end
        end
        S_T_SCAN: begin
          if (hit) begin
            b_word <= kw;
            if (span == 32'd0) begin
              f_r <= '0;
              st <= S_INTERP;
            end else begin
              st <= S_T_DIV;
            end
          end else begin
            a_word <= kw;
            if (scan_idx + CNT_W'(1) == n_r) begin
              b_word <= kw;
              f_r <= '0;
              st <= S_INTERP;
            end else begin
              scan_idx <= scan_idx + CNT_W'(1);
            end
          end
        end
        S_T_DIV: begin
          if (fdiv_rsp.done) begin
            f_r <= (fdiv_rsp.quot > Q_ONE) ? Q_ONE : fdiv_rsp.quot;
            st <= S_INTERP;
          end
        end
        S_INTERP: begin
          comp <= 2'd0;
          st <= (trk_sel == 2'd1) ? S_R_NA : S_L_M0;
        end
        S_L_M0: begin
          st <= S_L_M1;
        end
        S_L_M1: begin
          acc_l <= 66'(mul_q);
          st <= S_L_M2;
        end
        S_L_M2: begin
          if (trk_sel == 2'd0) begin
            unique case (comp)
              2'd0: res.trans_x <= lerp_val;
              2'd1: res.trans_y <= lerp_val;
              default: res.trans_z <= lerp_val;
            endcase
          end else begin
            unique case (comp)
              2'd0: res.scale_x <= lerp_val;
              2'd1: res.scale_y <= lerp_val;
              default: res.scale_z <= lerp_val;
            endcase
          end
          if (comp == 2'd2) begin
            st <= S_T_NEXT;
          end else begin
            comp <= comp + 2'd1;
            st <= S_L_M0;
          end
        end
        S_R_NA: begin
          st <= S_R_WA;
        end
        S_R_WA: begin
          if (norm_done) begin
            p <= norm_out;
            st <= S_R_NB;
          end
        end
        S_R_NB: begin
          st <= S_R_WB;
        end
        S_R_WB: begin
          if (norm_done) begin
            q <= norm_out;
            comp <= 2'd0;
            st <= S_R_DM;
          end
        end
        S_R_DM: begin
          dacc <= (comp == 2'd0) ? 36'sd0 : d_tot;
          if (comp == 2'd3) begin
            st <= S_R_DE;
          end else begin
            comp <= comp + 2'd1;
          end
        end
        S_R_DE: begin
          if (f_r >= Q_ONE) begin
            res.rot_x <= qsel[0][31:0];
            res.rot_y <= qsel[1][31:0];
            res.rot_z <= qsel[2][31:0];
            res.rot_w <= qsel[3][31:0];
            st <= S_T_NEXT;
          end else begin
            q <= qsel;
            bit_i <= 4'd15;
            st <= S_R_BS;
          end
        end
        S_R_BS: begin
          st <= S_R_BW;
        end
        S_R_BW: begin
          if (norm_done) begin
            if (f_r[bit_i]) begin
              p <= norm_out;
            end else begin
              q <= norm_out;
            end
            if (bit_i == 4'd0) begin
              st <= S_R_OUT;
            end else begin
              bit_i <= bit_i - 4'd1;
              st <= S_R_BS;
            end
          end
        end
        S_R_OUT: begin
          res.rot_x <= p[0][31:0];
          res.rot_y <= p[1][31:0];
          res.rot_z <= p[2][31:0];
          res.rot_w <= p[3][31:0];
          st <= S_T_NEXT;
        end
        S_T_NEXT: begin
          if (trk_sel == 2'd2) begin
            st <= S_FIN;
          end else begin
            trk_sel <= trk_sel + 2'd1;
            st <= S_T_CNT;
          end
        end
        S_FIN: begin
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/keyframe_pose_sampler_unit_tb.sv
// Self-checking testbench for the keyframe pose sampler with a built-in pose predictor.
module keyframe_pose_sampler_unit_tb;
  import kps_pkg::*;

  class pose_scoreboard;
    bit [31:0] key_time[NUM_SLOTS];
    bit [31:0] key_comp[NUM_SLOTS*4];
    int unsigned key_cnt[NUM_TRK];
    int unsigned chan_count;
    result_t pending[$];
    int mismatches;
    int checked;

    function new();
      foreach (key_cnt[i]) key_cnt[i] = 0;
      chan_count = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_count(bit [6:0] v);
      chan_count = v;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void unit_quat(input longint q[4], output longint o[4]);
      longint unsigned s, sq, n, mag[4];
      longint m;
      bit sat;
      s = 0;
      sat = 0;
      for (int i = 0; i < 4; i++) begin
        mag[i] = q[i] < 0 ? -q[i] : q[i];
        sq = mag[i] * mag[i];
        if (s > ~64'd0 - sq) sat = 1;
        else s += sq;
      end
      if (sat) s = ~64'd0;
      if (s == 0) begin
        o[0] = 0; o[1] = 0; o[2] = 0; o[3] = 65536;
        return;
      end
      n = root(s);
      for (int i = 0; i < 4; i++) begin
        m = ((mag[i] << 16) + n / 2) / n;
        o[i] = q[i] < 0 ? -m : m;
      end
    endfunction

    function void bracket(input int unsigned base, input int unsigned n, input bit [31:0] t,
                          output int unsigned ia, output int unsigned ib,
                          output longint unsigned f);
      bit [31:0] a, b, span;
      f = 0;
      if (n == 1 || t <= key_time[base]) begin
        ia = 0; ib = 0;
        return;
      end
      if (t >= key_time[base+n-1]) begin
        ia = n - 1; ib = n - 1;
        return;
      end
      for (int unsigned i = 0; i + 1 < n; i++) begin
        a = key_time[base+i];
        b = key_time[base+i+1];
        if (t >= a && t <= b) begin
          span = b - a;
          f = span != 0 ? ({32'd0, t - a} << 16) / {32'd0, span} : 0;
          if (f > 65536) f = 65536;
          ia = i; ib = i + 1;
          return;
        end
      end
      ia = n - 1; ib = n - 1;
    endfunction

    function void blend_vec(input int unsigned trk, input bit [31:0] t, input bit [31:0] dflt,
                            output bit [31:0] v[3]);
      int unsigned n, base, ia, ib;
      longint unsigned f, ua, ub, r;
      n = key_cnt[trk];
      base = trk * MAX_KEYS;
      if (n == 0) begin
        v[0] = dflt; v[1] = dflt; v[2] = dflt;
        return;
      end
      bracket(base, n, t, ia, ib, f);
      for (int c = 0; c < 3; c++) begin
        ua = {32'd0, key_comp[(base+ia)*4+c] ^ 32'h8000_0000};
        ub = {32'd0, key_comp[(base+ib)*4+c] ^ 32'h8000_0000};
        r = (ua * (65536 - f) + ub * f + 32768) >> 16;
        v[c] = r[31:0] ^ 32'h8000_0000;
      end
    endfunction

    function void blend_rot(input int unsigned trk, input bit [31:0] t, output longint res[4]);
      int unsigned n, base, ia, ib;
      longint unsigned f;
      longint ra[4], rb[4], p[4], q[4], m[4], mid[4];
      longint dot;
      n = key_cnt[trk];
      base = trk * MAX_KEYS;
      if (n == 0) begin
        res[0] = 0; res[1] = 0; res[2] = 0; res[3] = 65536;
        return;
      end
      bracket(base, n, t, ia, ib, f);
      for (int i = 0; i < 4; i++) begin
        ra[i] = longint'(signed'(key_comp[(base+ia)*4+i]));
        rb[i] = longint'(signed'(key_comp[(base+ib)*4+i]));
      end
      unit_quat(ra, p);
      unit_quat(rb, q);
      dot = 0;
      for (int i = 0; i < 4; i++) dot += p[i] * q[i];
      if (dot < 0) for (int i = 0; i < 4; i++) q[i] = -q[i];
      if (f >= 65536) begin
        res = q;
        return;
      end
      for (int b = 15; b >= 0; b--) begin
        for (int i = 0; i < 4; i++) m[i] = p[i] + q[i];
        unit_quat(m, mid);
        if (f[b]) p = mid;
        else q = mid;
      end
      res = p;
    endfunction

    function void note_item(item_t it);
      result_t e;
      int unsigned lim, trk, slot;
      bit [31:0] v[3];
      longint r[4];
      e = '0;
      lim = chan_count < MAX_CHANNELS ? chan_count : MAX_CHANNELS;
      if (it.cmd > CMD_CLEAR || it.channel >= lim) begin
        e.status = ST_RANGE;
        if (it.cmd == CMD_SAMPLE) begin
          e.rot_w = Q_ONE_W;
          e.scale_x = Q_ONE_W; e.scale_y = Q_ONE_W; e.scale_z = Q_ONE_W;
        end
      end else if (it.cmd == CMD_SAMPLE) begin
        e.status = ST_SAMPLED;
        blend_vec(it.channel * NUM_TRACKS, it.sample_time, 32'd0, v);
        e.trans_x = v[0]; e.trans_y = v[1]; e.trans_z = v[2];
        blend_rot(it.channel * NUM_TRACKS + 1, it.sample_time, r);
        e.rot_x = r[0][31:0]; e.rot_y = r[1][31:0];
        e.rot_z = r[2][31:0]; e.rot_w = r[3][31:0];
        blend_vec(it.channel * NUM_TRACKS + 2, it.sample_time, Q_ONE_W, v);
        e.scale_x = v[0]; e.scale_y = v[1]; e.scale_z = v[2];
      end else if (it.cmd == CMD_CLEAR) begin
        for (int i = 0; i < NUM_TRACKS; i++) key_cnt[it.channel*NUM_TRACKS+i] = 0;
        e.status = ST_STORED;
      end else begin
        trk = it.channel * NUM_TRACKS + it.cmd;
        if (key_cnt[trk] >= MAX_KEYS) begin
          e.status = ST_FULL;
        end else begin
          slot = trk * MAX_KEYS + key_cnt[trk];
          key_time[slot] = it.sample_time;
          key_comp[slot*4+0] = it.value_x;
          key_comp[slot*4+1] = it.value_y;
          key_comp[slot*4+2] = it.value_z;
          key_comp[slot*4+3] = it.value_w;
          key_cnt[trk]++;
          e.status = ST_STORED;
        end
      end
      pending.insert(pending.size(), e);
    endfunction

    function void check_result(result_t a);
      result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", a);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.status !== a.status || e.trans_x !== a.trans_x || e.trans_y !== a.trans_y ||
          e.trans_z !== a.trans_z || e.rot_w !== a.rot_w || e.rot_x !== a.rot_x ||
          e.rot_y !== a.rot_y || e.rot_z !== a.rot_z || e.scale_x !== a.scale_x ||
          e.scale_y !== a.scale_y || e.scale_z !== a.scale_z) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %h, got %h", e, a);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  item_t item = '0;
  logic busy, done;
  result_t result;
  logic cfg_we = 0;
  logic [6:0] cfg_data = '0;

  pose_scoreboard sb = new();
  int accepted = 0;
  int sender_idle = 0;
  bit [31:0] next_time[NUM_TRK];
  int samples = 0;
  int fulls = 0;

  keyframe_pose_sampler_unit dut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_item(item);
        accepted++;
        if (item.cmd == CMD_SAMPLE) samples++;
      end
      if (done) begin
        if (result.status == ST_FULL) fulls++;
        sb.check_result(result);
      end
    end
  end

  task automatic send(item_t it);
    int taken;
    taken = accepted;
    start = 1;
    item = it;
    @(negedge clk);
    while (accepted == taken) @(negedge clk);
    while ($urandom_range(99) < sender_idle) begin
      start = 0;
      @(negedge clk);
    end
  endtask

  task automatic cmd_item(bit [2:0] c, bit [6:0] ch, bit [31:0] t,
                          bit [31:0] x, bit [31:0] y, bit [31:0] z, bit [31:0] w);
    item_t it;
    it.cmd = c; it.channel = ch; it.sample_time = t;
    it.value_x = x; it.value_y = y; it.value_z = z; it.value_w = w;
    send(it);
  endtask

  task automatic drain();
    start = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_count(bit [6:0] v);
    drain();
    cfg_we = 1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 0;
    sb.set_count(v);
  endtask

  function automatic bit [31:0] rand_comp();
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
  endfunction

  task automatic random_run(int count, int chans);
    item_t it;
    int r, trk;
    logic [191:0] raw;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      it.channel = $urandom_range(0, chans);
      it.value_x = rand_comp(); it.value_y = rand_comp();
      it.value_z = rand_comp(); it.value_w = rand_comp();
      if (r < 55) begin
        it.cmd = $urandom_range(CMD_LOAD_T, CMD_LOAD_S);
        trk = (it.channel % MAX_CHANNELS) * NUM_TRACKS + it.cmd;
        if ($urandom_range(19) == 0) begin
          it.sample_time = $urandom;
        end else begin
          next_time[trk] += $urandom_range(0, 5000);
          it.sample_time = next_time[trk];
        end
      end else if (r < 78) begin
        it.cmd = CMD_SAMPLE;
        trk = (it.channel % MAX_CHANNELS) * NUM_TRACKS;
        it.sample_time = $urandom_range(19) == 0 ? $urandom :
                         $urandom_range(0, next_time[trk] + 2000);
      end else if (r < 81) begin
        it.cmd = CMD_CLEAR;
        it.sample_time = $urandom;
        for (int i = 0; i < NUM_TRACKS; i++)
          next_time[(it.channel % MAX_CHANNELS) * NUM_TRACKS + i] = 0;
      end else begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(item_t)-1:0];
      end
      send(it);
    end
  endtask

  initial begin
    foreach (next_time[i]) next_time[i] = 0;
    repeat (3) @(negedge clk);
    rst = 0;
    write_count(7'd64);
    cmd_item(CMD_SAMPLE, 0, 32'd50, 0, 0, 0, 0);
    cmd_item(CMD_SAMPLE, 127, 32'hffff_ffff, 0, 0, 0, 0);
    cmd_item(CMD_LOAD_T, 127, 0, 1, 2, 3, 4);
    cmd_item(3'd5, 0, 0, 0, 0, 0, 0);
    cmd_item(3'd6, 1, 0, 0, 0, 0, 0);
    cmd_item(3'd7, 63, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
             32'hffff_ffff);
    cmd_item(CMD_LOAD_T, 0, 32'd100, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 0);
    cmd_item(CMD_LOAD_T, 0, 32'd100, 32'h0000_1000, 32'hffff_0000, 32'h7fff_ffff, 0);
    cmd_item(CMD_LOAD_T, 0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
    cmd_item(CMD_LOAD_R, 0, 32'd100, 0, 0, 0, 0);
    cmd_item(CMD_LOAD_R, 0, 32'd300, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
             32'h7fff_ffff);
    cmd_item(CMD_LOAD_R, 0, 32'd900, 32'h0000_8000, 0, 0, 32'hffff_0000);
    cmd_item(CMD_LOAD_S, 0, 32'd200, 32'h0002_0000, 32'h0000_8000, 32'hffff_0000, 0);
    cmd_item(CMD_LOAD_S, 0, 32'd200, 32'h0003_0000, 32'h0000_0001, 32'h0001_0000, 0);
    cmd_item(CMD_SAMPLE, 0, 32'd0, 0, 0, 0, 0);
    cmd_item(CMD_SAMPLE, 0, 32'd100, 0, 0, 0, 0);
    cmd_item(CMD_SAMPLE, 0, 32'd200, 0, 0, 0, 0);
    cmd_item(CMD_SAMPLE, 0, 32'd600, 0, 0, 0, 0);
    cmd_item(CMD_SAMPLE, 0, 32'h8000_0000, 0, 0, 0, 0);
    cmd_item(CMD_SAMPLE, 0, 32'hffff_ffff, 0, 0, 0, 0);
    cmd_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    cmd_item(CMD_SAMPLE, 0, 32'd100, 0, 0, 0, 0);
    cmd_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);

    sender_idle = 38;
    write_count(7'd4);
    random_run(320, 5);
    sender_idle = 50;
    write_count(7'd127);
    random_run(300, 65);
    sender_idle = 0;
    write_count(7'd0);
    random_run(20, 3);
    write_count(7'd1);
    random_run(290, 1);
    drain();

    $display("covered %0d transactions, %0d samples, %0d full-track drops",
             accepted, samples, fulls);
    $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("keyframe_pose_sampler_unit_tb: done, clean");
    end else begin
      $display("keyframe_pose_sampler_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(12 * 8000000);
    $display("keyframe_pose_sampler_unit_tb: done, errors");
    $finish;
  end
endmodule

### keyframe_pose_sampler_unit.f
sv/kps_pkg.sv
sv/kps_ram.sv
sv/kps_div.sv
sv/kps_sqrt.sv
sv/kps_norm.sv
sv/keyframe_pose_sampler_unit.sv
tb/keyframe_pose_sampler_unit_tb.sv
